@@ hw/rtl/tok_scan_pkg.sv @@
`timescale 1ns / 1ps

package tok_scan_pkg;

   typedef struct packed {
      logic       kind;
      logic [7:0] source_byte;
   } req_data_type;

   typedef struct packed {
      logic [5:0]  token_code;
      logic [15:0] start_offset;
      logic [15:0] length;
      logic [15:0] line;
      logic [15:0] column;
      logic        last_of_run;
   } rsp_data_type;

   localparam logic KindByte = 1'b0;
   localparam logic KindEnd  = 1'b1;

   localparam logic [5:0] TokLeftParen    = 6'd0;
   localparam logic [5:0] TokRightParen   = 6'd1;
   localparam logic [5:0] TokLeftBrace    = 6'd2;
   localparam logic [5:0] TokRightBrace   = 6'd3;
   localparam logic [5:0] TokComma        = 6'd4;
   localparam logic [5:0] TokDot          = 6'd5;
   localparam logic [5:0] TokMinus        = 6'd6;
   localparam logic [5:0] TokPlus         = 6'd7;
   localparam logic [5:0] TokSemicolon    = 6'd8;
   localparam logic [5:0] TokStar         = 6'd9;
   localparam logic [5:0] TokBangEqual    = 6'd10;
   localparam logic [5:0] TokBang         = 6'd11;
   localparam logic [5:0] TokEqualEqual   = 6'd12;
   localparam logic [5:0] TokEqual        = 6'd13;
   localparam logic [5:0] TokLessEqual    = 6'd14;
   localparam logic [5:0] TokLess         = 6'd15;
   localparam logic [5:0] TokGreaterEqual = 6'd16;
   localparam logic [5:0] TokGreater      = 6'd17;
   localparam logic [5:0] TokSlash        = 6'd18;
   localparam logic [5:0] TokString       = 6'd19;
   localparam logic [5:0] TokNumber       = 6'd20;
   localparam logic [5:0] TokIdent        = 6'd21;
   localparam logic [5:0] TokKey0         = 6'd22;
   localparam logic [5:0] TokEnd          = 6'd36;
   localparam logic [5:0] TokErrChar      = 6'd37;
   localparam logic [5:0] TokErrString    = 6'd38;

   localparam logic [15:0] PosMax = 16'hFFFF;

   localparam int MaxResults    = 3;
   localparam int QueueDepth    = 8;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam int KeyCount  = 14;
   localparam int PrefixLen = 6;

   // and class else false fn fun for if nil or return let while print
   localparam logic [47:0] KeyText [KeyCount] = '{
      48'h000000646E61, 48'h007373616C63, 48'h000065736C65, 48'h0065736C6166,
      48'h000000006E66, 48'h0000006E7566, 48'h000000726F66, 48'h000000006669,
      48'h0000006C696E, 48'h00000000726F, 48'h6E7275746572, 48'h00000074656C,
      48'h00656C696877, 48'h00746E697270
   };

   localparam logic [2:0] KeyLength [KeyCount] = '{
      3'd3, 3'd5, 3'd4, 3'd5, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd2, 3'd6, 3'd3, 3'd5, 3'd5
   };

   function automatic logic [15:0] sat_sub(input logic [15:0] a, input logic [15:0] b);
      return (a > b) ? (a - b) : 16'd0;
   endfunction

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[16] ? PosMax : sum[15:0];
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
             || (c == 8'h5F);
   endfunction

   function automatic logic [5:0] word_code(input logic [47:0] prefix,
                                            input logic [15:0] len);
      logic [5:0] code;
      code = TokIdent;
      for (int k = KeyCount - 1; k >= 0; k--) begin
         if ((len == {13'd0, KeyLength[k]}) && (prefix == KeyText[k])) begin
            code = TokKey0 + 6'(k);
         end
      end
      return code;
   endfunction

   function automatic rsp_data_type make_token(input logic [5:0]  code,
                                               input logic [15:0] start,
                                               input logic [15:0] len,
                                               input logic [15:0] line,
                                               input logic [15:0] column);
      rsp_data_type t;
      t.token_code   = code;
      t.start_offset = start;
      t.length       = len;
      t.line         = line;
      t.column       = column;
      t.last_of_run  = 1'b0;
      return t;
   endfunction

endpackage

@@ hw/rtl/token_scanner.sv @@
// Streaming lexical scanner for a small scripting language.
// Input channel req_*: one item per transfer, either a source byte or an
// end-of-source marker (req_data.kind). Result channel rsp_*: one token per
// transfer with code, start offset, length, line and column; last_of_run
// marks the final token caused by one input item. An item may cause zero to
// three tokens.
// Flow: an accepted item is held in the item register and scanned from there;
// its tokens are written into the output queue as it is scanned, and with the
// queue empty its first token is then offered on rsp_valid.
// Throughput: one input item per cycle. The scan stage writes up to three
// tokens at once into an 8-entry output queue and takes the next item only
// while the queue has three free entries, so the rate is set by how fast
// the receiver drains tokens (one per cycle at most).
// Receiver stall: tokens wait in the queue; once fewer than three entries
// are free the scan stage holds its item and req_ready drops.
// Reset: queue empty, scanner idle at offset 0, line 1, column 1. The
// end-of-source item flushes any open token, emits the end token and
// returns the scanner to that same state for the next source text.
`timescale 1ns / 1ps

module token_scanner #(
   parameter int SOURCE_BYTES = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tok_scan_pkg::req_data_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output tok_scan_pkg::rsp_data_type rsp_data
);

   localparam logic [15:0] OffsetCap =
      ((SOURCE_BYTES - 1) > 65535) ? 16'hFFFF : 16'(SOURCE_BYTES - 1);

   localparam logic [2:0] PendNone    = 3'd0;
   localparam logic [2:0] PendBang    = 3'd1;
   localparam logic [2:0] PendEqual   = 3'd2;
   localparam logic [2:0] PendLess    = 3'd3;
   localparam logic [2:0] PendGreater = 3'd4;
   localparam logic [2:0] PendSlash   = 3'd5;

   localparam logic [tok_scan_pkg::QueueCntWidth-1:0] RoomLimit =
      tok_scan_pkg::QueueCntWidth'(tok_scan_pkg::QueueDepth - tok_scan_pkg::MaxResults);
   localparam logic [tok_scan_pkg::QueueCntWidth-1:0] FullCount =
      tok_scan_pkg::QueueCntWidth'(tok_scan_pkg::QueueDepth);

   typedef enum logic [2:0] {
      ModeIdle,
      ModeOp,
      ModeComment,
      ModeString,
      ModeInt,
      ModeIntDot,
      ModeFrac,
      ModeWord
   } mode_type;

   tok_scan_pkg::req_data_type item_ff;
   logic                       item_valid_ff;

   mode_type    mode_ff, mode_in;
   logic [2:0]  pend_ff, pend_in;
   logic [15:0] offset_ff, offset_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] start_line_ff, start_line_in;
   logic [15:0] start_col_ff, start_col_in;
   logic [15:0] line_ff, line_in;
   logic [15:0] col_ff, col_in;
   logic [47:0] prefix_ff, prefix_in;

   tok_scan_pkg::rsp_data_type queue_ff [tok_scan_pkg::QueueDepth];
   logic [tok_scan_pkg::QueuePtrWidth-1:0] head_ff, head_in;
   logic [tok_scan_pkg::QueuePtrWidth-1:0] tail_ff, tail_in;
   logic [tok_scan_pkg::QueueCntWidth-1:0] count_ff, count_in;

   logic process;
   logic pop;
   logic req_fire;

   logic [7:0]  c;
   logic [15:0] span_len;
   logic [15:0] digits;
   logic [5:0]  single_code;
   logic [5:0]  double_code;

   tok_scan_pkg::rsp_data_type close0, close1;
   logic [1:0]                 close_n;
   tok_scan_pkg::rsp_data_type tail_tok;
   logic                       tail_en;
   logic [1:0]                 fin_n;
   logic                       do_close;
   logic                       do_start;

   logic [5:0] st_code;
   logic       st_emit;
   mode_type   st_mode;
   logic [2:0] st_pend;

   tok_scan_pkg::rsp_data_type res [tok_scan_pkg::MaxResults];
   logic [1:0]                 push_n;

   assign process   = item_valid_ff && (count_ff <= RoomLimit);
   assign req_ready = !item_valid_ff || process;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = queue_ff[head_ff];

   always_comb begin
      c        = item_ff.source_byte;
      span_len = tok_scan_pkg::sat_sub(offset_ff, start_ff);
      digits   = tok_scan_pkg::sat_sub(tok_scan_pkg::sat_sub(offset_ff, 16'd1), start_ff);

      case (pend_ff)
         PendBang:    single_code = tok_scan_pkg::TokBang;
         PendEqual:   single_code = tok_scan_pkg::TokEqual;
         PendLess:    single_code = tok_scan_pkg::TokLess;
         PendGreater: single_code = tok_scan_pkg::TokGreater;
         default:     single_code = tok_scan_pkg::TokSlash;
      endcase
      case (pend_ff)
         PendBang:    double_code = tok_scan_pkg::TokBangEqual;
         PendLess:    double_code = tok_scan_pkg::TokLessEqual;
         PendGreater: double_code = tok_scan_pkg::TokGreaterEqual;
         default:     double_code = tok_scan_pkg::TokEqualEqual;
      endcase

      // tokens closed by the current mode
      close_n = 2'd0;
      close0  = '0;
      close1  = '0;
      unique case (mode_ff)
         ModeOp: begin
            close_n = 2'd1;
            close0  = tok_scan_pkg::make_token(single_code, start_ff, 16'd1,
                                               start_line_ff, start_col_ff);
         end
         ModeString: begin
            close_n = 2'd1;
            close0  = tok_scan_pkg::make_token(tok_scan_pkg::TokErrString, start_ff,
                                               span_len, start_line_ff, start_col_ff);
         end
         ModeInt, ModeFrac: begin
            close_n = 2'd1;
            close0  = tok_scan_pkg::make_token(tok_scan_pkg::TokNumber, start_ff,
                                               span_len, start_line_ff, start_col_ff);
         end
         ModeIntDot: begin
            close_n = 2'd2;
            close0  = tok_scan_pkg::make_token(tok_scan_pkg::TokNumber, start_ff,
                                               digits, start_line_ff, start_col_ff);
            close1  = tok_scan_pkg::make_token(tok_scan_pkg::TokDot,
                                               tok_scan_pkg::sat_add(start_ff, digits),
                                               16'd1, start_line_ff,
                                               tok_scan_pkg::sat_add(start_col_ff, digits));
         end
         ModeWord: begin
            close_n = 2'd1;
            close0  = tok_scan_pkg::make_token(tok_scan_pkg::word_code(prefix_ff, span_len),
                                               start_ff, span_len, start_line_ff,
                                               start_col_ff);
         end
         default: begin
            close_n = 2'd0;
         end
      endcase

      // first byte of a new token
      st_emit = 1'b1;
      st_mode = ModeIdle;
      st_pend = PendNone;
      st_code = tok_scan_pkg::TokErrChar;
      unique case (c) inside
         8'h28: st_code = tok_scan_pkg::TokLeftParen;
         8'h29: st_code = tok_scan_pkg::TokRightParen;
         8'h7B: st_code = tok_scan_pkg::TokLeftBrace;
         8'h7D: st_code = tok_scan_pkg::TokRightBrace;
         8'h2C: st_code = tok_scan_pkg::TokComma;
         8'h2E: st_code = tok_scan_pkg::TokDot;
         8'h2D: st_code = tok_scan_pkg::TokMinus;
         8'h2B: st_code = tok_scan_pkg::TokPlus;
         8'h3B: st_code = tok_scan_pkg::TokSemicolon;
         8'h2A: st_code = tok_scan_pkg::TokStar;
         8'h21: begin
            st_emit = 1'b0;
            st_mode = ModeOp;
            st_pend = PendBang;
         end
         8'h3D: begin
            st_emit = 1'b0;
            st_mode = ModeOp;
            st_pend = PendEqual;
         end
         8'h3C: begin
            st_emit = 1'b0;
            st_mode = ModeOp;
            st_pend = PendLess;
         end
         8'h3E: begin
            st_emit = 1'b0;
            st_mode = ModeOp;
            st_pend = PendGreater;
         end
         8'h2F: begin
            st_emit = 1'b0;
            st_mode = ModeOp;
            st_pend = PendSlash;
         end
         8'h20, 8'h0D, 8'h09, 8'h0A: st_emit = 1'b0;
         8'h22: begin
            st_emit = 1'b0;
            st_mode = ModeString;
         end
         default: begin
            if (tok_scan_pkg::is_digit(c)) begin
               st_emit = 1'b0;
               st_mode = ModeInt;
            end else if (tok_scan_pkg::is_alpha(c)) begin
               st_emit = 1'b0;
               st_mode = ModeWord;
            end
         end
      endcase

      mode_in       = mode_ff;
      pend_in       = pend_ff;
      offset_in     = offset_ff;
      start_in      = start_ff;
      start_line_in = start_line_ff;
      start_col_in  = start_col_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      prefix_in     = prefix_ff;
      do_close      = 1'b0;
      do_start      = 1'b0;
      tail_tok      = '0;
      tail_en       = 1'b0;

      if (item_ff.kind == tok_scan_pkg::KindEnd) begin
         do_close      = 1'b1;
         tail_tok      = tok_scan_pkg::make_token(tok_scan_pkg::TokEnd, offset_ff, 16'd0,
                                                  line_ff, col_ff);
         tail_en       = 1'b1;
         mode_in       = ModeIdle;
         pend_in       = PendNone;
         offset_in     = 16'd0;
         start_in      = 16'd0;
         start_line_in = 16'd1;
         start_col_in  = 16'd1;
         line_in       = 16'd1;
         col_in        = 16'd1;
         prefix_in     = 48'd0;
      end else begin
         unique case (mode_ff)
            ModeIdle: do_start = 1'b1;
            ModeOp: begin
               if ((pend_ff >= PendBang) && (pend_ff <= PendGreater) && (c == 8'h3D)) begin
                  tail_tok = tok_scan_pkg::make_token(double_code, start_ff, 16'd2,
                                                      start_line_ff, start_col_ff);
                  tail_en  = 1'b1;
                  mode_in  = ModeIdle;
                  pend_in  = PendNone;
               end else if ((pend_ff == PendSlash) && (c == 8'h2F)) begin
                  mode_in = ModeComment;
                  pend_in = PendNone;
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            ModeComment: begin
               if (c == 8'h0A) begin
                  mode_in = ModeIdle;
               end
            end
            ModeString: begin
               if (c == 8'h22) begin
                  tail_tok = tok_scan_pkg::make_token(tok_scan_pkg::TokString,
                                                      tok_scan_pkg::sat_add(start_ff, 16'd1),
                                                      tok_scan_pkg::sat_sub(span_len, 16'd1),
                                                      start_line_ff, start_col_ff);
                  tail_en  = 1'b1;
                  mode_in  = ModeIdle;
               end
            end
            ModeInt: begin
               if (c == 8'h2E) begin
                  mode_in = ModeIntDot;
               end else if (!tok_scan_pkg::is_digit(c)) begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            ModeIntDot: begin
               if (tok_scan_pkg::is_digit(c)) begin
                  mode_in = ModeFrac;
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            ModeFrac: begin
               if (!tok_scan_pkg::is_digit(c)) begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            ModeWord: begin
               if (tok_scan_pkg::is_alpha(c) || tok_scan_pkg::is_digit(c)) begin
                  if (span_len < 16'(tok_scan_pkg::PrefixLen)) begin
                     prefix_in = prefix_ff | (48'(c) << {span_len[2:0], 3'b000});
                  end
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            default: do_start = 1'b1;
         endcase

         if (do_start) begin
            start_in      = offset_ff;
            start_line_in = line_ff;
            start_col_in  = col_ff;
            mode_in       = st_mode;
            pend_in       = st_pend;
            if (st_mode == ModeWord) begin
               prefix_in = {40'd0, c};
            end
            tail_tok = tok_scan_pkg::make_token(st_code, offset_ff, 16'd1, line_ff, col_ff);
            tail_en  = st_emit;
         end

         offset_in = (offset_ff >= OffsetCap) ? OffsetCap : (offset_ff + 16'd1);
         if (c == 8'h0A) begin
            line_in = tok_scan_pkg::sat_add(line_ff, 16'd1);
            col_in  = 16'd1;
         end else begin
            col_in = tok_scan_pkg::sat_add(col_ff, 16'd1);
         end
      end

      fin_n = do_close ? close_n : 2'd0;

      res[0] = tail_tok;
      res[1] = '0;
      res[2] = '0;
      case (fin_n)
         2'd0: res[0] = tail_tok;
         2'd1: begin
            res[0] = close0;
            res[1] = tail_tok;
         end
         default: begin
            res[0] = close0;
            res[1] = close1;
            res[2] = tail_tok;
         end
      endcase
      push_n = fin_n + {1'b0, tail_en};
      for (int k = 0; k < tok_scan_pkg::MaxResults; k++) begin
         res[k].last_of_run = (2'(k) == (push_n - 2'd1));
      end

      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in = head_ff + tok_scan_pkg::QueuePtrWidth'(1);
      end
      if (process) begin
         tail_in = tail_ff + tok_scan_pkg::QueuePtrWidth'(push_n);
      end
      count_in = count_ff + (process ? tok_scan_pkg::QueueCntWidth'(push_n) : '0)
                 - tok_scan_pkg::QueueCntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         mode_ff       <= ModeIdle;
         pend_ff       <= PendNone;
         offset_ff     <= 16'd0;
         start_ff      <= 16'd0;
         start_line_ff <= 16'd1;
         start_col_ff  <= 16'd1;
         line_ff       <= 16'd1;
         col_ff        <= 16'd1;
         prefix_ff     <= 48'd0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
      end else begin
         if (req_fire) begin
            item_valid_ff <= 1'b1;
         end else if (process) begin
            item_valid_ff <= 1'b0;
         end
         if (process) begin
            mode_ff       <= mode_in;
            pend_ff       <= pend_in;
            offset_ff     <= offset_in;
            start_ff      <= start_in;
            start_line_ff <= start_line_in;
            start_col_ff  <= start_col_in;
            line_ff       <= line_in;
            col_ff        <= col_in;
            prefix_ff     <= prefix_in;
         end
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_data;
      end
      if (process) begin
         for (int k = 0; k < tok_scan_pkg::MaxResults; k++) begin
            if (2'(k) < push_n) begin
               queue_ff[tail_ff + tok_scan_pkg::QueuePtrWidth'(k)] <= res[k];
            end
         end
      end
   end

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("output queue count exceeds depth");

   a_offset_cap: assert property (@(posedge clock) disable iff (reset)
      offset_ff <= OffsetCap)
      else $error("byte offset beyond saturation point");

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      (process && (item_ff.kind == tok_scan_pkg::KindEnd)) |-> (push_n != 2'd0))
      else $error("end of source produced no end token");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (process && (item_ff.kind == tok_scan_pkg::KindEnd))
      |=> ((mode_ff == ModeIdle) && (offset_ff == 16'd0) && (line_ff == 16'd1)
           && (col_ff == 16'd1)))
      else $error("scanner not restarted after end of source");

   a_hold_when_full: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && (count_ff > RoomLimit)) |-> !req_ready)
      else $error("input taken while scan stage blocked");
`endif

endmodule

@@ tb/sv/token_stream_checker.sv @@
`timescale 1ns / 1ps

module token_stream_checker #(
   parameter int SOURCE_BYTES = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  tok_scan_pkg::req_data_type req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  tok_scan_pkg::rsp_data_type rsp_data,
   output int                         mismatch_count,
   output int                         tokens_outstanding
);

   typedef enum logic [2:0] {
      ScanIdle, ScanOperator, ScanComment, ScanString,
      ScanInteger, ScanIntDot, ScanFraction, ScanWord
   } scan_state_type;

   typedef enum logic [2:0] {
      OpNone, OpBang, OpEqual, OpLess, OpGreater, OpSlash
   } pending_op_type;

   localparam int OffsetLimit = (SOURCE_BYTES - 1 > 65535) ? 65535 : SOURCE_BYTES - 1;
   localparam int PositionLimit = 65535;
   localparam logic [7:0] CarriageReturn = 8'h0D;

   scan_state_type state;
   pending_op_type pending_op;
   int             cursor_offset;
   int             cursor_line;
   int             cursor_column;
   int             token_offset;
   int             token_line;
   int             token_column;
   logic [47:0]    prefix;

   tok_scan_pkg::rsp_data_type expected_tokens[$];
   tok_scan_pkg::rsp_data_type item_tokens[$];

   function automatic int clamp_add(input int a, input int b, input int limit);
      return (a + b > limit) ? limit : a + b;
   endfunction

   function automatic int floor_sub(input int a, input int b);
      return (a > b) ? a - b : 0;
   endfunction

   function automatic bit is_digit_char(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_word_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic string keyword_text(input int k);
      case (k)
         0:  return "and";
         1:  return "class";
         2:  return "else";
         3:  return "false";
         4:  return "fn";
         5:  return "fun";
         6:  return "for";
         7:  return "if";
         8:  return "nil";
         9:  return "or";
         10: return "return";
         11: return "let";
         12: return "while";
         default: return "print";
      endcase
   endfunction

   // prefix holds the first six characters, first character in the low byte
   function automatic logic [5:0] classify_word();
      int          len;
      string       w;
      logic [47:0] word_bits;
      len = floor_sub(cursor_offset, token_offset);
      if (len > 6) return tok_scan_pkg::TokIdent;
      for (int k = 0; k < tok_scan_pkg::KeyCount; k++) begin
         w = keyword_text(k);
         word_bits = '0;
         for (int i = 0; i < w.len(); i++) word_bits |= 48'(w[i]) << (8 * i);
         if (w.len() == len && word_bits == prefix) return tok_scan_pkg::TokKey0 + 6'(k);
      end
      return tok_scan_pkg::TokIdent;
   endfunction

   function automatic logic [5:0] lone_op_code(input pending_op_type op);
      case (op)
         OpBang:    return tok_scan_pkg::TokBang;
         OpEqual:   return tok_scan_pkg::TokEqual;
         OpLess:    return tok_scan_pkg::TokLess;
         OpGreater: return tok_scan_pkg::TokGreater;
         default:   return tok_scan_pkg::TokSlash;
      endcase
   endfunction

   function automatic logic [5:0] paired_op_code(input pending_op_type op);
      case (op)
         OpBang:  return tok_scan_pkg::TokBangEqual;
         OpEqual: return tok_scan_pkg::TokEqualEqual;
         OpLess:  return tok_scan_pkg::TokLessEqual;
         default: return tok_scan_pkg::TokGreaterEqual;
      endcase
   endfunction

   task automatic queue_token(input logic [5:0] code, input int first, input int len,
                              input int ln, input int col);
      tok_scan_pkg::rsp_data_type t;
      if (item_tokens.size() < tok_scan_pkg::MaxResults) begin
         t.token_code   = code;
         t.start_offset = 16'(first);
         t.length       = 16'(len);
         t.line         = 16'(ln);
         t.column       = 16'(col);
         t.last_of_run  = 1'b0;
         item_tokens.push_back(t);
      end
   endtask

   task automatic add_number();
      queue_token(tok_scan_pkg::TokNumber, token_offset,
                  floor_sub(cursor_offset, token_offset), token_line, token_column);
   endtask

   // number whose trailing dot turned out not to start a fraction
   task automatic add_number_and_dot();
      int digits;
      digits = floor_sub(floor_sub(cursor_offset, 1), token_offset);
      queue_token(tok_scan_pkg::TokNumber, token_offset, digits, token_line, token_column);
      queue_token(tok_scan_pkg::TokDot, clamp_add(token_offset, digits, PositionLimit), 1,
                  token_line, clamp_add(token_column, digits, PositionLimit));
   endtask

   task automatic add_word();
      queue_token(classify_word(), token_offset, floor_sub(cursor_offset, token_offset),
                  token_line, token_column);
   endtask

   task automatic restart_scan();
      state         = ScanIdle;
      pending_op    = OpNone;
      cursor_offset = 0;
      cursor_line   = 1;
      cursor_column = 1;
      token_offset  = 0;
      token_line    = 1;
      token_column  = 1;
      prefix        = '0;
   endtask

   task automatic open_token(input logic [7:0] c);
      token_offset = cursor_offset;
      token_line   = cursor_line;
      token_column = cursor_column;
      state        = ScanIdle;
      pending_op   = OpNone;
      case (c)
         "(": queue_token(tok_scan_pkg::TokLeftParen, cursor_offset, 1,
                          cursor_line, cursor_column);
         ")": queue_token(tok_scan_pkg::TokRightParen, cursor_offset, 1,
                          cursor_line, cursor_column);
         "{": queue_token(tok_scan_pkg::TokLeftBrace, cursor_offset, 1,
                          cursor_line, cursor_column);
         "}": queue_token(tok_scan_pkg::TokRightBrace, cursor_offset, 1,
                          cursor_line, cursor_column);
         ",": queue_token(tok_scan_pkg::TokComma, cursor_offset, 1,
                          cursor_line, cursor_column);
         ".": queue_token(tok_scan_pkg::TokDot, cursor_offset, 1,
                          cursor_line, cursor_column);
         "-": queue_token(tok_scan_pkg::TokMinus, cursor_offset, 1,
                          cursor_line, cursor_column);
         "+": queue_token(tok_scan_pkg::TokPlus, cursor_offset, 1,
                          cursor_line, cursor_column);
         ";": queue_token(tok_scan_pkg::TokSemicolon, cursor_offset, 1,
                          cursor_line, cursor_column);
         "*": queue_token(tok_scan_pkg::TokStar, cursor_offset, 1,
                          cursor_line, cursor_column);
         "!": begin
            pending_op = OpBang;
            state      = ScanOperator;
         end
         "=": begin
            pending_op = OpEqual;
            state      = ScanOperator;
         end
         "<": begin
            pending_op = OpLess;
            state      = ScanOperator;
         end
         ">": begin
            pending_op = OpGreater;
            state      = ScanOperator;
         end
         "/": begin
            pending_op = OpSlash;
            state      = ScanOperator;
         end
         " ", "\t", "\n", CarriageReturn: ;
         "\"": state = ScanString;
         default: begin
            if (is_digit_char(c)) begin
               state = ScanInteger;
            end else if (is_word_char(c)) begin
               prefix = {40'd0, c};
               state  = ScanWord;
            end else begin
               queue_token(tok_scan_pkg::TokErrChar, cursor_offset, 1, cursor_line,
                           cursor_column);
            end
         end
      endcase
   endtask

   task automatic scan_byte(input logic [7:0] c);
      int len;
      case (state)
         ScanOperator: begin
            if (pending_op != OpSlash && c == "=") begin
               queue_token(paired_op_code(pending_op), token_offset, 2, token_line,
                           token_column);
               state      = ScanIdle;
               pending_op = OpNone;
            end else if (pending_op == OpSlash && c == "/") begin
               state      = ScanComment;
               pending_op = OpNone;
            end else begin
               queue_token(lone_op_code(pending_op), token_offset, 1, token_line,
                           token_column);
               open_token(c);
            end
         end
         ScanComment: begin
            if (c == "\n") state = ScanIdle;
         end
         ScanString: begin
            if (c == "\"") begin
               queue_token(tok_scan_pkg::TokString, clamp_add(token_offset, 1, PositionLimit),
                           floor_sub(floor_sub(cursor_offset, token_offset), 1),
                           token_line, token_column);
               state = ScanIdle;
            end
         end
         ScanInteger: begin
            if (c == ".") begin
               state = ScanIntDot;
            end else if (!is_digit_char(c)) begin
               add_number();
               open_token(c);
            end
         end
         ScanIntDot: begin
            if (is_digit_char(c)) begin
               state = ScanFraction;
            end else begin
               add_number_and_dot();
               open_token(c);
            end
         end
         ScanFraction: begin
            if (!is_digit_char(c)) begin
               add_number();
               open_token(c);
            end
         end
         ScanWord: begin
            if (is_word_char(c) || is_digit_char(c)) begin
               len = floor_sub(cursor_offset, token_offset);
               if (len < 6) prefix |= 48'(c) << (8 * len);
            end else begin
               add_word();
               open_token(c);
            end
         end
         default: open_token(c);
      endcase
      cursor_offset = clamp_add(cursor_offset, 1, OffsetLimit);
      if (c == "\n") begin
         cursor_line   = clamp_add(cursor_line, 1, PositionLimit);
         cursor_column = 1;
      end else begin
         cursor_column = clamp_add(cursor_column, 1, PositionLimit);
      end
   endtask

   task automatic close_source();
      case (state)
         ScanOperator: queue_token(lone_op_code(pending_op), token_offset, 1, token_line,
                                   token_column);
         ScanString: queue_token(tok_scan_pkg::TokErrString, token_offset,
                                 floor_sub(cursor_offset, token_offset),
                                 token_line, token_column);
         ScanInteger, ScanFraction: add_number();
         ScanIntDot: add_number_and_dot();
         ScanWord: add_word();
         default: ;
      endcase
      queue_token(tok_scan_pkg::TokEnd, cursor_offset, 0, cursor_line, cursor_column);
      restart_scan();
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      tok_scan_pkg::rsp_data_type want;
      tok_scan_pkg::rsp_data_type t;
      if (reset) begin
         restart_scan();
         expected_tokens.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               $error("token_code: expected none, actual %0d", rsp_data.token_code);
               mismatch_count++;
            end else begin
               want = expected_tokens.pop_front();
               compare_field("token_code", want.token_code, rsp_data.token_code);
               compare_field("start_offset", want.start_offset, rsp_data.start_offset);
               compare_field("length", want.length, rsp_data.length);
               compare_field("line", want.line, rsp_data.line);
               compare_field("column", want.column, rsp_data.column);
               compare_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
            end
         end
         if (req_valid && req_ready) begin
            item_tokens.delete();
            if (req_data.kind == tok_scan_pkg::KindEnd) begin
               close_source();
            end else begin
               scan_byte(req_data.source_byte);
            end
            if (item_tokens.size() > 0) begin
               t = item_tokens.pop_back();
               t.last_of_run = 1'b1;
               item_tokens.push_back(t);
            end
            foreach (item_tokens[i]) expected_tokens.push_back(item_tokens[i]);
         end
      end
      tokens_outstanding = expected_tokens.size();
   end

endmodule

@@ tb/sv/token_scanner_tb.sv @@
`timescale 1ns / 1ps

module token_scanner_tb;

   localparam int SourceBytes   = 65536;
   localparam int RandomItems   = 130;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   tok_scan_pkg::req_data_type req_data;
   logic                       rsp_valid;
   logic                       rsp_ready;
   tok_scan_pkg::rsp_data_type rsp_data;

   int mismatch_count;
   int tokens_outstanding;
   int scored_items;
   bit bursts_off;

   token_scanner #(
      .SOURCE_BYTES(SourceBytes)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   token_stream_checker #(
      .SOURCE_BYTES(SourceBytes)
   ) token_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data),
      .mismatch_count    (mismatch_count),
      .tokens_outstanding(tokens_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("[token_scanner] ERROR");
      $finish;
   end

   // receiver: stall in random bursts
   initial begin : drain
      int stall;
      rsp_ready = 1'b0;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (!bursts_off && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(0, 8);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic kind, input logic [7:0] value);
      tok_scan_pkg::req_data_type r;
      r.kind        = kind;
      r.source_byte = value;
      if (!bursts_off && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (kind == tok_scan_pkg::KindEnd || !(value inside {" ", "\t", "\n", 8'h0D})) begin
         scored_items++;
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(tok_scan_pkg::KindByte, s[i]);
   endtask

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 3))
         0: return " ";
         1: return "\t";
         2: return 8'h0D;
         default: return "\n";
      endcase
   endfunction

   function automatic logic [7:0] word_char(input bit first);
      string alphabet;
      alphabet = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      return alphabet[$urandom_range(0, first ? 52 : 62)];
   endfunction

   function automatic logic [7:0] digit_char();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   // one mostly well-formed lexeme, sometimes noise
   task automatic send_fragment();
      string       singles;
      string       pairables;
      logic [7:0]  c;
      singles   = "(){},.-+;*";
      pairables = "!=<>";
      case ($urandom_range(0, 11))
         0: begin
            case ($urandom_range(0, 13))
               0:  send_text("and");
               1:  send_text("class");
               2:  send_text("else");
               3:  send_text("false");
               4:  send_text("fn");
               5:  send_text("fun");
               6:  send_text("for");
               7:  send_text("if");
               8:  send_text("nil");
               9:  send_text("or");
               10: send_text("return");
               11: send_text("let");
               12: send_text("while");
               default: send_text("print");
            endcase
         end
         1: begin
            send_item(tok_scan_pkg::KindByte, word_char(1'b1));
            repeat ($urandom_range(0, 7)) send_item(tok_scan_pkg::KindByte, word_char(1'b0));
         end
         2: begin
            repeat ($urandom_range(1, 4)) send_item(tok_scan_pkg::KindByte, digit_char());
            if ($urandom_range(0, 1) == 1) begin
               send_item(tok_scan_pkg::KindByte, ".");
               repeat ($urandom_range(0, 3)) send_item(tok_scan_pkg::KindByte, digit_char());
            end
         end
         3: begin
            send_item(tok_scan_pkg::KindByte, "\"");
            repeat ($urandom_range(0, 5)) begin
               c = 8'($urandom_range(32, 126));
               if (c == "\"") c = "\n";
               send_item(tok_scan_pkg::KindByte, c);
            end
            if ($urandom_range(0, 7) != 0) send_item(tok_scan_pkg::KindByte, "\"");
         end
         4, 5: send_item(tok_scan_pkg::KindByte, singles[$urandom_range(0, 9)]);
         6, 7: begin
            send_item(tok_scan_pkg::KindByte, pairables[$urandom_range(0, 3)]);
            if ($urandom_range(0, 1) == 1) send_item(tok_scan_pkg::KindByte, "=");
         end
         8: begin
            send_text("//");
            repeat ($urandom_range(0, 4)) begin
               send_item(tok_scan_pkg::KindByte, 8'($urandom_range(32, 126)));
            end
            send_item(tok_scan_pkg::KindByte, "\n");
         end
         9: send_item(tok_scan_pkg::KindByte, blank_char());
         10: send_item(tok_scan_pkg::KindByte, 8'($urandom_range(0, 255)));
         default: send_item(tok_scan_pkg::KindByte, "/");
      endcase
      if ($urandom_range(0, 1) == 1) send_item(tok_scan_pkg::KindByte, blank_char());
   endtask

   initial begin : stimulus
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      bursts_off   = 1'b0;
      scored_items = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      send_text("1.x");
      send_item(tok_scan_pkg::KindEnd, 8'h00);
      send_text("\"s\nq");
      send_item(tok_scan_pkg::KindEnd, 8'hFF);
      send_item(tok_scan_pkg::KindByte, 8'hFF);
      send_item(tok_scan_pkg::KindByte, 8'h00);
      send_item(tok_scan_pkg::KindByte, 8'h80);
      send_text("/");
      send_item(tok_scan_pkg::KindEnd, 8'h5A);
      send_text("7.");
      send_item(tok_scan_pkg::KindEnd, 8'hA5);
      send_text("//c\n>");
      send_item(tok_scan_pkg::KindEnd, 8'h3C);
      send_text("\"ab\" x<=9.5");
      send_item(tok_scan_pkg::KindEnd, 8'h00);

      scored_items = 0;
      while (scored_items < RandomItems) begin
         if (scored_items > RandomItems * 3 / 4) bursts_off = 1'b1;
         repeat ($urandom_range(2, 8)) send_fragment();
         send_item(tok_scan_pkg::KindEnd, 8'($urandom()));
      end
      req_valid <= 1'b0;

      while (tokens_outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("[token_scanner] OK");
      end else begin
         $display("[token_scanner] ERROR");
      end
      $finish;
   end

endmodule

@@ token_scanner.f @@
hw/rtl/tok_scan_pkg.sv
hw/rtl/token_scanner.sv
tb/sv/token_stream_checker.sv
tb/sv/token_scanner_tb.sv
